// ===== hdl/fr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types, constants and helpers of the fast root unit.
// ----------------------------------------------------------------------------
package fr_pkg;

   // seed constants and float literals (bit patterns)
   localparam logic [31:0] RSQRT_MAGIC   = 32'h5f3759df;
   localparam logic [31:0] ROOT_MAGIC    = 32'h5f375a86;
   localparam logic [31:0] HALF_BITS     = 32'h3f000000;
   localparam logic [31:0] ONE_HALF_BITS = 32'h3fc00000;
   localparam logic [31:0] DEFAULT_NAN   = 32'hffc00000;
   localparam logic [31:0] QUIET_BIT     = 32'h00400000;

   // command codes
   localparam logic CMD_RSQRT = 1'b0;
   localparam logic CMD_SQRT  = 1'b1;

   // values that travel alongside each item through the pipeline
   typedef struct packed {
      logic        cmd;
      logic [31:0] x;
      logic [31:0] half;
      logic [31:0] y;
      logic [31:0] t;
      logic [31:0] rsq;
   } side_type;

   // leading zero count of a 48-bit word, 48 when zero
   function automatic logic [5:0] lead_zeros(input logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n     = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

// ===== hdl/fr_chan_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_chan_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface fr_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] operand_bits;
   modport source (output valid, command, operand_bits, input ready);
   modport sink   (input valid, command, operand_bits, output ready);
endinterface

interface fr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_bits;
   modport source (output valid, result_bits, input ready);
   modport sink   (input valid, result_bits, output ready);
endinterface

// ===== hdl/fast_root_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_root_unit
// Approximate reciprocal square root (command 0) and square root
// (command 1) from a bit-pattern seed and Newton steps in single precision.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  req_chan  in    command, operand_bits
//  rsp_chan  out   result_bits
//
//  one beat in and one beat out per cycle sustained while rsp_chan.ready stays high;
//  the chain is ten floating-point units of three register stages each
//  every item runs the full chain; command 0 takes the first Newton result
//  reset (synchronous) empties all stages; no state between items
//  a stalled output fills bubbles upstream before req_chan.ready drops
module fast_root_unit (
   input  logic      clock,
   input  logic      reset,
   fr_req_if.sink    req_chan,
   fr_rsp_if.source  rsp_chan
);

   localparam int UNITS = 10;

   fr_pkg::side_type side_in  [UNITS];
   fr_pkg::side_type side_out [UNITS];
   logic [31:0]      op_a [UNITS];
   logic [31:0]      op_b [UNITS];
   logic [31:0]      res  [UNITS];
   logic             u_valid [UNITS];
   logic             u_ready [UNITS];
   logic             o_valid [UNITS];
   logic             o_ready [UNITS];

   assign req_chan.ready = u_ready[0];

   // operand selection for each unit of the chain
   always_comb begin
      for (int k = 0; k < UNITS; k++) begin
         case (k)
            0: begin
               op_a[k] = side_in[k].x;
               op_b[k] = fr_pkg::HALF_BITS;
            end
            1, 5: begin
               op_a[k] = side_in[k].half;
               op_b[k] = side_in[k].y;
            end
            2, 6: begin
               op_a[k] = side_in[k].t;
               op_b[k] = side_in[k].y;
            end
            3, 7: begin
               op_a[k] = fr_pkg::ONE_HALF_BITS;
               op_b[k] = side_in[k].t;
            end
            4, 8: begin
               op_a[k] = side_in[k].y;
               op_b[k] = side_in[k].t;
            end
            default: begin
               op_a[k] = side_in[k].x;
               op_b[k] = side_in[k].y;
            end
         endcase
      end
   end

   // entry side data with the integer seed, then fold each unit result
   // back into the side data for the next unit
   always_comb begin
      side_in[0].cmd  = req_chan.command;
      side_in[0].x    = req_chan.operand_bits;
      side_in[0].half = 32'd0;
      side_in[0].y    = ((req_chan.command == fr_pkg::CMD_SQRT) ? fr_pkg::ROOT_MAGIC
                                                              : fr_pkg::RSQRT_MAGIC)
                        - {1'b0, req_chan.operand_bits[31:1]};
      side_in[0].t    = 32'd0;
      side_in[0].rsq  = 32'd0;
      u_valid[0]       = req_chan.valid;
      o_ready[UNITS-1] = rsp_chan.ready;
      for (int k = 1; k < UNITS; k++) begin
         side_in[k] = side_out[k-1];
         case (k - 1)
            0: side_in[k].half = res[k-1];
            1, 2, 3, 5, 6, 7: side_in[k].t = res[k-1];
            4: begin
               side_in[k].y   = res[k-1];
               side_in[k].rsq = res[k-1];
            end
            default: side_in[k].y = res[k-1];
         endcase
         u_valid[k]   = o_valid[k-1];
         o_ready[k-1] = u_ready[k];
      end
   end

   // the unit chain
   for (genvar k = 0; k < UNITS; k++) begin : g_unit
      if (k == 3 || k == 7) begin : g_sub
         fr_fsub u_sub (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (u_valid[k]),
            .in_ready  (u_ready[k]),
            .op_a      (op_a[k]),
            .op_b      (op_b[k]),
            .side_in   (side_in[k]),
            .out_valid (o_valid[k]),
            .out_ready (o_ready[k]),
            .result    (res[k]),
            .side_out  (side_out[k])
         );
      end else begin : g_mul
         fr_fmul u_mul (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (u_valid[k]),
            .in_ready  (u_ready[k]),
            .op_a      (op_a[k]),
            .op_b      (op_b[k]),
            .side_in   (side_in[k]),
            .out_valid (o_valid[k]),
            .out_ready (o_ready[k]),
            .result    (res[k]),
            .side_out  (side_out[k])
         );
      end
   end

   // response beat
   assign rsp_chan.valid       = o_valid[UNITS-1];
   assign rsp_chan.result_bits = (side_out[UNITS-1].cmd == fr_pkg::CMD_SQRT)
                                 ? res[UNITS-1] : side_out[UNITS-1].rsq;

endmodule

// ===== hdl/fr_fmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_fmul
// Three-stage single-precision multiplier, round to nearest even,
// with subnormal support and side data carried along.
// ----------------------------------------------------------------------------
module fr_fmul (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      op_a,
   input  logic [31:0]      op_b,
   input  fr_pkg::side_type side_in,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      result,
   output fr_pkg::side_type side_out
);

   // stage handshake
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign out_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: unpack, special cases, significand product
   logic [47:0]      p1_in, p1_ff;
   logic [8:0]       esum1_in, esum1_ff;
   logic             sg1_in, sg1_ff, spc1_in, spc1_ff;
   logic [31:0]      spr1_in, spr1_ff;
   fr_pkg::side_type sd1_ff;

   always_comb begin
      logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [7:0] ea_eff, eb_eff;
      a_nan  = (op_a[30:23] == 8'hff) && (op_a[22:0] != 23'd0);
      b_nan  = (op_b[30:23] == 8'hff) && (op_b[22:0] != 23'd0);
      a_inf  = (op_a[30:23] == 8'hff) && (op_a[22:0] == 23'd0);
      b_inf  = (op_b[30:23] == 8'hff) && (op_b[22:0] == 23'd0);
      a_zero = (op_a[30:0] == 31'd0);
      b_zero = (op_b[30:0] == 31'd0);
      sg1_in = op_a[31] ^ op_b[31];
      ea_eff = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
      eb_eff = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
      esum1_in = {1'b0, ea_eff} + {1'b0, eb_eff};
      p1_in = {24'd0, (op_a[30:23] != 8'd0), op_a[22:0]}
            * {24'd0, (op_b[30:23] != 8'd0), op_b[22:0]};
      spc1_in = 1'b1;
      if (a_nan)                                    spr1_in = op_a | fr_pkg::QUIET_BIT;
      else if (b_nan)                               spr1_in = op_b | fr_pkg::QUIET_BIT;
      else if ((a_inf && b_zero) || (a_zero && b_inf)) spr1_in = fr_pkg::DEFAULT_NAN;
      else if (a_inf || b_inf)                      spr1_in = {sg1_in, 8'hff, 23'd0};
      else if (a_zero || b_zero)                    spr1_in = {sg1_in, 31'd0};
      else begin
         spc1_in = 1'b0;
         spr1_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_ff    <= p1_in;
         esum1_ff <= esum1_in;
         sg1_ff   <= sg1_in;
         spc1_ff  <= spc1_in;
         spr1_ff  <= spr1_in;
         sd1_ff   <= side_in;
      end
   end

   // stage 2: locate leading one, pick exponent and shift
   logic [47:0]        p2_ff;
   logic signed [9:0]  r2_in, r2_ff;
   logic signed [10:0] e2_in, e2_ff;
   logic               sg2_ff, spc2_ff;
   logic [31:0]        spr2_ff;
   fr_pkg::side_type   sd2_ff;

   always_comb begin
      logic [5:0]         lead;
      logic [5:0]         l_pos;
      logic signed [10:0] e_norm;
      lead   = fr_pkg::lead_zeros(p1_ff);
      l_pos  = 6'd47 - lead;
      e_norm = $signed({5'd0, l_pos}) + $signed({2'd0, esum1_ff}) - 11'sd173;
      if (e_norm >= 11'sd1) begin
         e2_in = e_norm;
         r2_in = $signed({4'd0, l_pos}) - 10'sd23;
      end else begin
         e2_in = 11'sd1;
         r2_in = 10'sd151 - $signed({1'b0, esum1_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         p2_ff   <= p1_ff;
         r2_ff   <= r2_in;
         e2_ff   <= e2_in;
         sg2_ff  <= sg1_ff;
         spc2_ff <= spc1_ff;
         spr2_ff <= spr1_ff;
         sd2_ff  <= sd1_ff;
      end
   end

   // stage 3: align, round to nearest even, pack
   logic [31:0]      res3_in, res3_ff;
   fr_pkg::side_type sd3_ff;

   always_comb begin
      logic [47:0] wide, gb, mask;
      logic [5:0]  rc;
      logic [4:0]  lsh;
      logic [23:0] m;
      logic        g, st;
      logic [24:0] mr;
      logic [33:0] packed_v;
      logic [10:0] e_m1;
      g   = 1'b0;
      st  = 1'b0;
      rc  = 6'd0;
      lsh = 5'd0;
      gb  = 48'd0;
      mask = 48'd0;
      if (r2_ff < 10'sd0) begin
         lsh  = 5'(-r2_ff);
         wide = p2_ff << lsh;
      end else begin
         rc   = (r2_ff > 10'sd63) ? 6'd63 : r2_ff[5:0];
         wide = p2_ff >> rc;
         if (rc != 6'd0) begin
            gb   = p2_ff >> (rc - 6'd1);
            g    = gb[0];
            mask = (48'd1 << (rc - 6'd1)) - 48'd1;
            st   = |(p2_ff & mask);
         end
      end
      m        = wide[23:0];
      mr       = {1'b0, m} + {24'd0, g & (st | m[0])};
      e_m1     = 11'(e2_ff - 11'sd1);
      packed_v = {e_m1, 23'd0} + {9'd0, mr};
      if (spc2_ff)
         res3_in = spr2_ff;
      else if (packed_v[33:23] >= 11'd255)
         res3_in = {sg2_ff, 8'hff, 23'd0};
      else
         res3_in = {sg2_ff, packed_v[30:0]};
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         res3_ff <= res3_in;
         sd3_ff  <= sd2_ff;
      end
   end

   assign result   = res3_ff;
   assign side_out = sd3_ff;

`ifndef ASSERT_OFF
   // full pipe is the only reason to refuse a beat
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("fr_fmul: ready low with a free stage");
   // a waiting result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> (out_valid && $stable(result)))
      else $error("fr_fmul: stalled result lost");
   // reset empties the pipe
   a_reset: assert property (@(posedge clock)
      reset |=> !(v1_ff || v2_ff || v3_ff))
      else $error("fr_fmul: stage valid after reset");
`endif

endmodule

// ===== hdl/fr_fsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_fsub
// Three-stage single-precision subtractor a - b, round to nearest even,
// with subnormal support and side data carried along.
// ----------------------------------------------------------------------------
module fr_fsub (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [31:0]      op_a,
   input  logic [31:0]      op_b,
   input  fr_pkg::side_type side_in,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      result,
   output fr_pkg::side_type side_out
);

   // stage handshake
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign in_ready  = rdy1;
   assign out_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: specials, order by magnitude, align smaller operand
   logic [26:0]      ma1_in, ma1_ff, al1_in, al1_ff;
   logic [7:0]       e1_in, e1_ff;
   logic             sg1_in, sg1_ff, sub1_in, sub1_ff, zs1_in, zs1_ff;
   logic             spc1_in, spc1_ff;
   logic [31:0]      spr1_in, spr1_ff;
   fr_pkg::side_type sd1_ff;

   always_comb begin
      logic        a_nan, b_nan, a_inf, b_inf, swap, sb_eff, s_small;
      logic [7:0]  eb_big, eb_small, e_small;
      logic [22:0] f_big, f_small;
      logic [7:0]  d;
      logic [4:0]  dc;
      logic [26:0] m_small, mask;
      a_nan = (op_a[30:23] == 8'hff) && (op_a[22:0] != 23'd0);
      b_nan = (op_b[30:23] == 8'hff) && (op_b[22:0] != 23'd0);
      a_inf = (op_a[30:23] == 8'hff) && (op_a[22:0] == 23'd0);
      b_inf = (op_b[30:23] == 8'hff) && (op_b[22:0] == 23'd0);
      sb_eff = ~op_b[31];
      swap   = op_b[30:0] > op_a[30:0];
      sg1_in   = swap ? sb_eff : op_a[31];
      s_small  = swap ? op_a[31] : sb_eff;
      eb_big   = swap ? op_b[30:23] : op_a[30:23];
      f_big    = swap ? op_b[22:0] : op_a[22:0];
      eb_small = swap ? op_a[30:23] : op_b[30:23];
      f_small  = swap ? op_a[22:0] : op_b[22:0];
      e1_in    = (eb_big == 8'd0) ? 8'd1 : eb_big;
      e_small  = (eb_small == 8'd0) ? 8'd1 : eb_small;
      d        = e1_in - e_small;
      dc       = (d > 8'd31) ? 5'd31 : d[4:0];
      ma1_in   = {(eb_big != 8'd0), f_big, 3'd0};
      m_small  = {(eb_small != 8'd0), f_small, 3'd0};
      mask     = (27'd1 << dc) - 27'd1;
      al1_in   = (m_small >> dc) | {26'd0, |(m_small & mask)};
      sub1_in  = sg1_in != s_small;
      zs1_in   = sub1_in ? 1'b0 : sg1_in;
      spc1_in  = 1'b1;
      if (a_nan)                                  spr1_in = op_a | fr_pkg::QUIET_BIT;
      else if (b_nan)                             spr1_in = op_b | fr_pkg::QUIET_BIT;
      else if (a_inf && b_inf && (op_a[31] == op_b[31])) spr1_in = fr_pkg::DEFAULT_NAN;
      else if (a_inf)                             spr1_in = op_a;
      else if (b_inf)                             spr1_in = {sb_eff, 8'hff, 23'd0};
      else begin
         spc1_in = 1'b0;
         spr1_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ma1_ff  <= ma1_in;
         al1_ff  <= al1_in;
         e1_ff   <= e1_in;
         sg1_ff  <= sg1_in;
         sub1_ff <= sub1_in;
         zs1_ff  <= zs1_in;
         spc1_ff <= spc1_in;
         spr1_ff <= spr1_in;
         sd1_ff  <= side_in;
      end
   end

   // stage 2: add or subtract magnitudes, count leading zeros
   logic [27:0]      s2_in, s2_ff;
   logic [5:0]       lz2_in, lz2_ff;
   logic [7:0]       e2_ff;
   logic             sg2_ff, zs2_ff, spc2_ff;
   logic [31:0]      spr2_ff;
   fr_pkg::side_type sd2_ff;

   always_comb begin
      s2_in  = sub1_ff ? ({1'b0, ma1_ff} - {1'b0, al1_ff})
                       : ({1'b0, ma1_ff} + {1'b0, al1_ff});
      lz2_in = fr_pkg::lead_zeros({s2_in[26:0], 21'h1fffff});
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ff   <= s2_in;
         lz2_ff  <= lz2_in;
         e2_ff   <= e1_ff;
         sg2_ff  <= sg1_ff;
         zs2_ff  <= zs1_ff;
         spc2_ff <= spc1_ff;
         spr2_ff <= spr1_ff;
         sd2_ff  <= sd1_ff;
      end
   end

   // stage 3: normalize, round to nearest even, pack
   logic [31:0]      res3_in, res3_ff;
   fr_pkg::side_type sd3_ff;

   always_comb begin
      logic [7:0]  elim, sh;
      logic [26:0] n27;
      logic [8:0]  e_fin;
      logic [23:0] m;
      logic        g, st;
      logic [24:0] mr;
      logic [10:0] e_m1;
      logic [33:0] packed_v;
      elim = e2_ff - 8'd1;
      sh   = ({2'd0, lz2_ff} < elim) ? {2'd0, lz2_ff} : elim;
      if (s2_ff[27]) begin
         n27   = {s2_ff[27:2], s2_ff[1] | s2_ff[0]};
         e_fin = {1'b0, e2_ff} + 9'd1;
      end else begin
         n27   = s2_ff[26:0] << sh;
         e_fin = {1'b0, e2_ff} - {1'b0, sh};
      end
      m        = n27[26:3];
      g        = n27[2];
      st       = |n27[1:0];
      mr       = {1'b0, m} + {24'd0, g & (st | m[0])};
      e_m1     = {2'd0, e_fin} - 11'd1;
      packed_v = {e_m1, 23'd0} + {9'd0, mr};
      if (spc2_ff)
         res3_in = spr2_ff;
      else if (s2_ff == 28'd0)
         res3_in = {zs2_ff, 31'd0};
      else if (packed_v[33:23] >= 11'd255)
         res3_in = {sg2_ff, 8'hff, 23'd0};
      else
         res3_in = {sg2_ff, packed_v[30:0]};
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         res3_ff <= res3_in;
         sd3_ff  <= sd2_ff;
      end
   end

   assign result   = res3_ff;
   assign side_out = sd3_ff;

endmodule

// ===== tb/fr_root_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_root_checker
// Watches the request and response channels of the fast root unit and
// predicts each result with a bit-level single-precision model. Each response
// beat is compared with the oldest prediction. The failure count and the
// number of results still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module fr_root_checker (
   input  logic clock,
   input  logic reset,
   fr_req_if    req_mon,
   fr_rsp_if    rsp_mon,
   output int   fail_count,
   output int   owed_count
);

   logic [31:0] root_expect[$];

   function automatic logic is_nan(input logic [31:0] v);
      return v[30:23] == 8'hff && v[22:0] != 23'd0;
   endfunction

   function automatic logic is_inf(input logic [31:0] v);
      return v[30:23] == 8'hff && v[22:0] == 23'd0;
   endfunction

   function automatic logic is_zero(input logic [31:0] v);
      return v[30:0] == 31'd0;
   endfunction

   // finite value as mant * 2^e
   function automatic void split_float(input logic [31:0] v, output logic [23:0] m,
                                       output int e);
      m = (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
      e = ((v[30:23] == 8'd0) ? 1 : int'(v[30:23])) - 150;
   endfunction

   // round m * 2^e to nearest even, with subnormals and overflow to infinity
   function automatic logic [31:0] round_pack(input logic s, input int e,
                                              input logic [63:0] m);
      int          p;
      int          lsb;
      int          sh;
      logic [63:0] sig;
      logic        rb;
      logic        st;
      if (m == 64'd0) return {s, 31'd0};
      p = 63;
      while (!m[p]) p--;
      lsb = e + p - 23;
      if (lsb < -149) lsb = -149;
      sh  = lsb - e;
      rb  = 1'b0;
      st  = 1'b0;
      if (sh <= 0) begin
         sig = m << (-sh);
      end else if (sh > 64) begin
         sig = 64'd0;
         st  = 1'b1;
      end else begin
         sig = (sh == 64) ? 64'd0 : (m >> sh);
         rb  = m[sh-1];
         st  = |(m & ((64'd1 << (sh - 1)) - 64'd1));
      end
      if (rb && (st || sig[0])) sig++;
      if (sig == 64'h100_0000) begin
         sig = 64'h80_0000;
         lsb++;
      end
      if (!sig[23]) return {s, 8'd0, sig[22:0]};
      if (lsb + 150 >= 255) return {s, 8'hff, 23'd0};
      return {s, 8'(lsb + 150), sig[22:0]};
   endfunction

   // single-precision product, first operand's nan wins
   function automatic logic [31:0] fl_mul(input logic [31:0] a, input logic [31:0] b);
      logic [23:0] ma;
      logic [23:0] mb;
      int          ea;
      int          eb;
      logic        s;
      s = a[31] ^ b[31];
      if (is_nan(a)) return a | fr_pkg::QUIET_BIT;
      if (is_nan(b)) return b | fr_pkg::QUIET_BIT;
      if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
         return fr_pkg::DEFAULT_NAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hff, 23'd0};
      if (is_zero(a) || is_zero(b)) return {s, 31'd0};
      split_float(a, ma, ea);
      split_float(b, mb, eb);
      return round_pack(s, ea + eb, 64'(ma) * 64'(mb));
   endfunction

   // single-precision a - b
   function automatic logic [31:0] fl_sub(input logic [31:0] a, input logic [31:0] b);
      logic [23:0] ma;
      logic [23:0] mb;
      logic [31:0] nb;
      logic [31:0] tmp;
      logic [63:0] wa;
      logic [63:0] wb;
      int          ea;
      int          eb;
      int          d;
      if (is_nan(a)) return a | fr_pkg::QUIET_BIT;
      if (is_nan(b)) return b | fr_pkg::QUIET_BIT;
      nb = {~b[31], b[30:0]};
      if (is_inf(a) && is_inf(nb)) return (a[31] == nb[31]) ? a : fr_pkg::DEFAULT_NAN;
      if (is_inf(a)) return a;
      if (is_inf(nb)) return nb;
      if (is_zero(a) && is_zero(nb)) return {a[31] & nb[31], 31'd0};
      if (is_zero(a)) return nb;
      if (is_zero(nb)) return a;
      split_float(a, ma, ea);
      split_float(nb, mb, eb);
      if (ea < eb) begin
         tmp = a;
         a   = nb;
         nb  = tmp;
         split_float(a, ma, ea);
         split_float(nb, mb, eb);
      end
      d  = ea - eb;
      wa = 64'(ma) << 38;
      // smaller operand aligned, lost bits jammed into the lsb
      if (d <= 38) wb = 64'(mb) << (38 - d);
      else if (d - 38 >= 64) wb = 64'(mb != 24'd0);
      else wb = (64'(mb) >> (d - 38)) | 64'(|(64'(mb) & ((64'd1 << (d - 38)) - 64'd1)));
      if (a[31] == nb[31]) return round_pack(a[31], ea - 38, wa + wb);
      if (wa == wb) return 32'd0;
      if (wa > wb) return round_pack(a[31], ea - 38, wa - wb);
      return round_pack(nb[31], ea - 38, wb - wa);
   endfunction

   function automatic logic [31:0] newton_refine(input logic [31:0] half,
                                                 input logic [31:0] y);
      logic [31:0] t;
      t = fl_mul(half, y);
      t = fl_mul(t, y);
      t = fl_sub(fr_pkg::ONE_HALF_BITS, t);
      return fl_mul(y, t);
   endfunction

   function automatic logic [31:0] predict_root(input logic cmd, input logic [31:0] x);
      logic [31:0] half;
      logic [31:0] y;
      half = fl_mul(x, fr_pkg::HALF_BITS);
      if (cmd == fr_pkg::CMD_RSQRT)
         return newton_refine(half, fr_pkg::RSQRT_MAGIC - (x >> 1));
      y = newton_refine(half, fr_pkg::ROOT_MAGIC - (x >> 1));
      y = newton_refine(half, y);
      return fl_mul(x, y);
   endfunction

   assign owed_count = root_expect.size();

   initial fail_count = 0;

   // predict on request beats, compare on response beats
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            root_expect.push_back(predict_root(req_mon.command, req_mon.operand_bits));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (root_expect.size() == 0) begin
               $error("result_bits: none expected, actual %h", rsp_mon.result_bits);
               fail_count++;
            end else begin
               want = root_expect.pop_front();
               if (rsp_mon.result_bits !== want) begin
                  $error("result_bits: expected %h, actual %h", want, rsp_mon.result_bits);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// ===== tb/fast_root_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fast_root_unit_test
// Drives directed and random operands of both commands into the fast root
// unit with random idle cycles on both channels and one long response stall,
// then reports the verdict from the checker's failure and owed counts.
// ----------------------------------------------------------------------------
module fast_root_unit_test;

   logic clock;
   logic reset;
   int   fail_count;
   int   owed_count;

   fr_req_if req_chan ();
   fr_rsp_if rsp_chan ();

   fast_root_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   fr_root_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .owed_count (owed_count)
   );

   // clock generation
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit
   initial begin
      #3ms;
      $display("fast_root_unit verification failed");
      $finish;
   end

   // send one beat, with an optional idle cycle first
   task automatic send_operand(input logic cmd, input logic [31:0] bits, input bit calm);
      if (!calm && $urandom_range(99) < 11) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.operand_bits <= bits;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // response side: random stalls, a quiet window and one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= 600 && cyc < 800) rsp_chan.ready <= 1'b0;
         else if (cyc >= 1000 && cyc < 1400) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(99) >= 11);
      end
   end

   // stimulus and verdict
   initial begin
      logic [31:0] corner[15];
      logic [31:0] val;
      int          waited;
      corner = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h7f80_0001, 32'hffff_ffff, 32'h0000_0001,
                 32'h007f_ffff, 32'h0080_0000, 32'h3f80_0000, 32'h7f7f_ffff,
                 32'h4080_0000, 32'hbf80_0000, 32'h3e80_0000};
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= fr_pkg::CMD_RSQRT;
      req_chan.operand_bits <= 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner operands under both commands
      foreach (corner[i]) begin
         send_operand(fr_pkg::CMD_RSQRT, corner[i], 1'b0);
         send_operand(fr_pkg::CMD_SQRT, corner[i], 1'b0);
      end

      // random operands: mostly positive normals, some raw patterns
      for (int n = 0; n < 1200; n++) begin
         if ($urandom_range(3) == 0) val = $urandom;
         else val = {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
         send_operand(($urandom_range(1) == 1) ? fr_pkg::CMD_SQRT : fr_pkg::CMD_RSQRT,
                      val, n >= 300 && n < 600);
      end
      req_chan.valid <= 1'b0;

      // drain
      waited = 0;
      while (owed_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (owed_count == 0 && fail_count == 0)
         $display("fast_root_unit verification clean");
      else
         $display("fast_root_unit verification failed");
      $finish;
   end

endmodule
